[sv/aifp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the ASCII integer field parser.
// No dependencies; every other file of the block refers to it by scoped names.
package aifp_pkg;

  localparam int ACT_BITS       = 2;
  localparam int CH_BITS        = 8;
  localparam int WIDTH_BITS     = 16;
  localparam int VALUE_OUT_BITS = 64;
  localparam int CFG_IDX_BITS   = 1;
  localparam int DIGIT_BITS     = 4;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_START = 2'd0,
    ACT_CHAR  = 2'd1,
    ACT_END   = 2'd2,
    ACT_NONE  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    RADIX_AUTO = 2'd0,
    RADIX_OCT  = 2'd1,
    RADIX_DEC  = 2'd2,
    RADIX_HEX  = 2'd3
  } radix_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RADIX_MODE  = 1'b0,
    REG_FIELD_WIDTH = 1'b1
  } cfg_reg_e;

  localparam logic [CH_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_BITS-1:0] CH_UP_A  = 8'h41;
  localparam logic [CH_BITS-1:0] CH_UP_F  = 8'h46;
  localparam logic [CH_BITS-1:0] CH_UP_X  = 8'h58;
  localparam logic [CH_BITS-1:0] CH_LOW_A = 8'h61;
  localparam logic [CH_BITS-1:0] CH_LOW_F = 8'h66;
  localparam logic [CH_BITS-1:0] CH_LOW_X = 8'h78;

  localparam logic [DIGIT_BITS-1:0] DIG_LETTER_OFS = 4'd9;
  localparam logic [DIGIT_BITS-1:0] DIG_OCT_LIMIT  = 4'd8;
  localparam logic [DIGIT_BITS-1:0] DIG_DEC_LIMIT  = 4'd10;

  // A classified character word, as handed from the front to the back.
  typedef struct packed {
    act_e                  act;
    logic                  is_ws;
    logic                  is_minus;
    logic                  is_plus;
    logic                  is_zero;
    logic                  is_x;
    logic                  is_hex;   // digit value below sixteen
    logic [DIGIT_BITS-1:0] dig;
  } aifp_item_t;

  typedef struct packed {
    logic                      consumed;
    logic                      done_res;
    logic                      ok;
    logic [VALUE_OUT_BITS-1:0] value;
  } aifp_result_t;

endpackage

[sv/aifp_intf.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the parser: input words, result words and
// configuration writes. Depends on aifp_pkg for the field widths.
interface aifp_in_if;
  logic                               valid;
  logic                               ready;
  logic [aifp_pkg::ACT_BITS-1:0]      action;
  logic [aifp_pkg::CH_BITS-1:0]       ch;
  modport source (output valid, action, ch, input ready);
  modport sink (input valid, action, ch, output ready);
endinterface

interface aifp_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    consumed;
  logic                                    done_res;
  logic                                    ok;
  logic signed [aifp_pkg::VALUE_OUT_BITS-1:0] value;
  modport source (output valid, consumed, done_res, ok, value, input ready);
  modport sink (input valid, consumed, done_res, ok, value, output ready);
endinterface

interface aifp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [aifp_pkg::CFG_IDX_BITS-1:0]   index;
  logic [aifp_pkg::WIDTH_BITS-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/aifp_front.sv]
`timescale 1ns / 1ps
// Front of the parser: accepts input words and classifies the character.
// Depends on aifp_pkg and aifp_intf.
module aifp_front (
  aifp_in_if.sink               in_if,
  output logic                  push_valid_o,
  output aifp_pkg::aifp_item_t  push_item_o,
  input  logic                  push_ready_i
);

  logic [aifp_pkg::CH_BITS-1:0] ch;
  logic is_dec, is_low_hex, is_up_hex;

  assign ch           = in_if.ch;
  assign in_if.ready  = push_ready_i;
  assign push_valid_o = in_if.valid;

  assign is_dec     = (ch >= aifp_pkg::CH_ZERO) && (ch <= aifp_pkg::CH_NINE);
  assign is_low_hex = (ch >= aifp_pkg::CH_LOW_A) && (ch <= aifp_pkg::CH_LOW_F);
  assign is_up_hex  = (ch >= aifp_pkg::CH_UP_A) && (ch <= aifp_pkg::CH_UP_F);

  always_comb begin
    push_item_o.act      = aifp_pkg::act_e'(in_if.action);
    push_item_o.is_ws    = (ch == aifp_pkg::CH_SPACE) ||
                           ((ch >= aifp_pkg::CH_TAB) && (ch <= aifp_pkg::CH_CR));
    push_item_o.is_minus = (ch == aifp_pkg::CH_MINUS);
    push_item_o.is_plus  = (ch == aifp_pkg::CH_PLUS);
    push_item_o.is_zero  = (ch == aifp_pkg::CH_ZERO);
    push_item_o.is_x     = (ch == aifp_pkg::CH_LOW_X) || (ch == aifp_pkg::CH_UP_X);
    push_item_o.is_hex   = is_dec || is_low_hex || is_up_hex;
    // Letters a-f and A-F share their low nibble, one above the digit value minus ten.
    if (is_dec) begin
      push_item_o.dig = ch[aifp_pkg::DIGIT_BITS-1:0];
    end else begin
      push_item_o.dig = ch[aifp_pkg::DIGIT_BITS-1:0] + aifp_pkg::DIG_LETTER_OFS;
    end
  end

endmodule

[sv/aifp_fifo.sv]
`timescale 1ns / 1ps
// Short queue of classified words between the front and the back.
// Depends on aifp_pkg for the word type.
module aifp_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  input  aifp_pkg::aifp_item_t  push_item_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output aifp_pkg::aifp_item_t  pop_item_o,
  input  logic                  pop_ready_i
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);

  aifp_pkg::aifp_item_t mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != CntBits'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[sv/aifp_back.sv]
`timescale 1ns / 1ps
// Back of the parser: conversion state machine, accumulator and result register.
// Depends on aifp_pkg and aifp_intf.
module aifp_back #(
  parameter int VALUE_BITS = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  aifp_pkg::aifp_item_t             item_i,
  output logic                             ready_o,
  input  aifp_pkg::radix_e                 radix_mode_i,
  input  logic [aifp_pkg::WIDTH_BITS-1:0]  field_width_i,
  aifp_out_if.source                       out_if
);

  localparam int CmpBits = (COUNT_BITS > aifp_pkg::WIDTH_BITS) ? COUNT_BITS
                                                                 : aifp_pkg::WIDTH_BITS;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_WS     = 5'b00010,
    PH_PRE0   = 5'b00100,
    PH_PREX   = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [COUNT_BITS-1:0]   cnt_q, cnt_d;
  logic [VALUE_BITS-1:0]   acc_q, acc_d;
  logic                    neg_q, neg_d;
  logic                    seen_q, seen_d;
  aifp_pkg::radix_e        radix_q, radix_d;
  aifp_pkg::aifp_result_t  res_d, out_q;
  logic                    out_valid_q;
  logic                    fire, fin;

  function automatic logic width_hit(logic [COUNT_BITS-1:0] cnt,
                                     logic [aifp_pkg::WIDTH_BITS-1:0] fw);
    width_hit = (fw != '0) && (CmpBits'(cnt) >= CmpBits'(fw));
  endfunction

  assign ready_o = !out_valid_q || out_if.ready;
  assign fire    = valid_i && ready_o;

  always_comb begin
    logic take, took, consumed, in_pre0, in_prex, in_dig, pre_next, dig_ok;
    logic [VALUE_BITS-1:0] scaled, dig_ext;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    seen_d   = seen_q;
    radix_d  = radix_q;
    take     = 1'b0;
    took     = 1'b0;
    consumed = 1'b0;
    fin      = 1'b0;
    in_pre0  = 1'b0;
    in_prex  = 1'b0;
    in_dig   = 1'b0;
    pre_next = (radix_q == aifp_pkg::RADIX_AUTO) || (radix_q == aifp_pkg::RADIX_HEX);
    dig_ok   = 1'b0;
    scaled   = '0;
    dig_ext  = VALUE_BITS'(item_i.dig);
    case (item_i.act)
      aifp_pkg::ACT_START: begin
        phase_d = PH_WS;
        cnt_d   = '0;
        acc_d   = '0;
        neg_d   = 1'b0;
        seen_d  = 1'b0;
        radix_d = radix_mode_i;
      end
      aifp_pkg::ACT_END: begin
        fin = (phase_q != PH_IDLE);
      end
      aifp_pkg::ACT_CHAR: begin
        if (phase_q != PH_IDLE) begin
          if ((phase_q == PH_WS) && item_i.is_ws) begin
            consumed = 1'b1;
          end else if (width_hit(cnt_q, field_width_i)) begin
            fin = 1'b1;
          end else begin
            if (phase_q == PH_WS) begin
              // First character after whitespace: optional sign.
              if (item_i.is_minus || item_i.is_plus) begin
                neg_d   = item_i.is_minus;
                take    = 1'b1;
                phase_d = pre_next ? PH_PRE0 : PH_DIGITS;
              end else if (pre_next) begin
                in_pre0 = 1'b1;
              end else begin
                in_dig = 1'b1;
              end
            end else begin
              in_pre0 = (phase_q == PH_PRE0);
              in_prex = (phase_q == PH_PREX);
              in_dig  = (phase_q == PH_DIGITS);
            end
            if (in_pre0) begin
              if (item_i.is_zero) begin
                seen_d  = 1'b1;
                take    = 1'b1;
                phase_d = PH_PREX;
              end else begin
                if (radix_q == aifp_pkg::RADIX_AUTO) begin
                  radix_d = aifp_pkg::RADIX_DEC;
                end
                in_dig = 1'b1;
              end
            end
            if (in_prex) begin
              if (item_i.is_x) begin
                radix_d = aifp_pkg::RADIX_HEX;
                take    = 1'b1;
                phase_d = PH_DIGITS;
              end else begin
                if (radix_q == aifp_pkg::RADIX_AUTO) begin
                  radix_d = aifp_pkg::RADIX_OCT;
                end
                in_dig = 1'b1;
              end
            end
            if (in_dig) begin
              case (radix_d)
                aifp_pkg::RADIX_HEX: begin
                  dig_ok = item_i.is_hex;
                  scaled = acc_q << 4;
                end
                aifp_pkg::RADIX_OCT: begin
                  dig_ok = item_i.is_hex && (item_i.dig < aifp_pkg::DIG_OCT_LIMIT);
                  scaled = acc_q << 3;
                end
                default: begin
                  dig_ok = item_i.is_hex && (item_i.dig < aifp_pkg::DIG_DEC_LIMIT);
                  scaled = (acc_q << 3) + (acc_q << 1);
                end
              endcase
              if (dig_ok) begin
                acc_d   = neg_q ? scaled - dig_ext : scaled + dig_ext;
                seen_d  = 1'b1;
                take    = 1'b1;
                phase_d = PH_DIGITS;
              end else begin
                fin = 1'b1;
              end
            end
            if (take) begin
              if (cnt_q != '1) begin
                cnt_d = cnt_q + COUNT_BITS'(1);
              end
              if (width_hit(cnt_d, field_width_i)) begin
                fin  = 1'b1;
                took = 1'b1;
              end else begin
                consumed = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (fin) begin
      phase_d = PH_IDLE;
    end
    res_d.consumed = consumed || took;
    res_d.done_res = fin;
    res_d.ok       = fin && seen_d;
    res_d.value    = (fin && seen_d) ? aifp_pkg::VALUE_OUT_BITS'(signed'(acc_d)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      seen_q      <= 1'b0;
      radix_q     <= aifp_pkg::RADIX_DEC;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        seen_q  <= seen_d;
        radix_q <= radix_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.consumed = out_q.consumed;
  assign out_if.done_res = out_q.done_res;
  assign out_if.ok       = out_q.ok;
  assign out_if.value    = signed'(out_q.value);

  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.ok |-> out_q.done_res)
    else $error("ok result without done");

  a_fail_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.ok |-> out_q.value == '0)
    else $error("non-zero value on a word without ok");

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && fin |=> phase_q == PH_IDLE)
    else $error("conversion did not end after done");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (item_i.act == aifp_pkg::ACT_START) |=>
      (phase_q == PH_WS) && (cnt_q == '0) && !seen_q)
    else $error("start word did not open a fresh conversion");

endmodule

[sv/ascii_integer_field_parser.sv]
`timescale 1ns / 1ps
// Top level of the ASCII integer field parser: front, queue, back and config.
// Depends on aifp_pkg, aifp_intf, aifp_front, aifp_fifo and aifp_back.

// The parser reads one signed integer, scanf style, from text that arrives one
// character word at a time on in_if. A start word (action 0) opens a conversion
// using the radix mode and field width held in the configuration registers;
// each character word (action 1) then yields exactly one result word on
// out_if, and an end word (action 2) closes the conversion. Every input word,
// including start words and words that arrive while no conversion is open,
// produces one result word, in order. The block sustains one word per clock while
// out_if does not stall: the front classifies each character in the cycle it is
// accepted and pushes it into a two-entry queue, and the back updates the
// accumulator with a single shift-and-add step (times 8, 10 or 16, plus or minus
// the digit) per cycle. A word passes through the queue and then the result
// register, which presents its result on out_if, and a stalled output only stops
// intake once the queue and the result register are full.
// Configuration words on cfg_if are always accepted and must only be sent
// while no conversion words are in flight.
module ascii_integer_field_parser #(
  parameter int VALUE_BITS = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aifp_in_if.sink     in_if,
  aifp_out_if.source  out_if,
  aifp_cfg_if.sink    cfg_if
);

  aifp_pkg::radix_e                 radix_mode_q;
  logic [aifp_pkg::WIDTH_BITS-1:0]  field_width_q;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  aifp_pkg::aifp_item_t  push_item, pop_item;

  // Configuration registers. The back reads them directly; the user must change them
  // only while no words are queued or in process; the block does not enforce it.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_mode_q  <= aifp_pkg::RADIX_DEC;
      field_width_q <= '0;
    end else if (cfg_if.valid) begin
      unique case (aifp_pkg::cfg_reg_e'(cfg_if.index))
        aifp_pkg::REG_RADIX_MODE:  radix_mode_q  <= aifp_pkg::radix_e'(cfg_if.data[1:0]);
        aifp_pkg::REG_FIELD_WIDTH: field_width_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Front: takes a word and tags the character (whitespace, sign, prefix,
  // digit value) so the back only selects on flags.
  aifp_front u_front (
    .in_if        (in_if),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // The queue lets the front keep accepting while the back waits on out_if.
  aifp_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // Back: conversion state, accumulator and the registered result word.
  aifp_back #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (pop_valid),
    .item_i        (pop_item),
    .ready_o       (pop_ready),
    .radix_mode_i  (radix_mode_q),
    .field_width_i (field_width_q),
    .out_if        (out_if)
  );

endmodule

[tb/tb_ascii_integer_field_parser.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the ASCII integer field parser: a table of directed words,
// then random numbers and noise against a predictor.
// Depends on aifp_pkg, the channel interfaces in aifp_intf and the parser top level.
module tb_ascii_integer_field_parser;

  localparam int unsigned LIMIT_CYCLES  = 200_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned ITEM_COUNT    = 1900;
  localparam int unsigned PHASE_WORDS   = 150;

  // Progress of one conversion, as the parser sees it.
  typedef enum logic [2:0] {
    FP_IDLE, FP_SPACE, FP_SIGN, FP_LEAD_ZERO, FP_PREFIX_X, FP_DIGITS
  } field_phase_e;

  // One row of the directed table: an input word or a register write. Where
  // typed is set, want holds the result read straight off the behavior.
  typedef struct packed {
    logic                                is_reg;
    logic                                typed;
    aifp_pkg::act_e                      act;
    aifp_pkg::cfg_reg_e                  reg_idx;
    logic [aifp_pkg::WIDTH_BITS-1:0]     arg;      // character, or register data
    aifp_pkg::aifp_result_t              want;
  } step_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  aifp_in_if  in_if ();
  aifp_out_if out_if ();
  aifp_cfg_if cfg_if ();

  ascii_integer_field_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers.
  aifp_pkg::radix_e                mode_reg;
  logic [aifp_pkg::WIDTH_BITS-1:0] width_reg;

  // Predicted state of the running conversion.
  field_phase_e          fld_phase;
  logic [15:0]           fld_count;
  logic [63:0]           fld_value;
  logic                  fld_negative;
  logic                  fld_has_digit;
  logic [4:0]            fld_base;

  aifp_pkg::aifp_result_t awaited_results [$];
  int unsigned  fail_count;
  int unsigned  sent_words;
  int unsigned  cycle_count;
  logic         idling;

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic is_space(logic [7:0] c);
    return c == aifp_pkg::CH_SPACE || (c >= aifp_pkg::CH_TAB && c <= aifp_pkg::CH_CR);
  endfunction

  // Digit weight of a character, letters counting from ten; 255 if none.
  function automatic logic [7:0] digit_weight(logic [7:0] c);
    if (c >= aifp_pkg::CH_ZERO && c <= aifp_pkg::CH_NINE) return c - aifp_pkg::CH_ZERO;
    if (c >= aifp_pkg::CH_LOW_A && c <= "z") return c - aifp_pkg::CH_LOW_A + 8'd10;
    if (c >= aifp_pkg::CH_UP_A && c <= "Z") return c - aifp_pkg::CH_UP_A + 8'd10;
    return 8'hFF;
  endfunction

  function automatic logic width_used_up();
    return width_reg != '0 && fld_count >= width_reg;
  endfunction

  // Closes the conversion and forms its final result word.
  function automatic aifp_pkg::aifp_result_t close_field(logic took);
    aifp_pkg::aifp_result_t r;
    r.consumed = took;
    r.done_res = 1'b1;
    r.ok       = fld_has_digit;
    r.value    = fld_has_digit ? fld_value : '0;
    fld_phase  = FP_IDLE;
    return r;
  endfunction

  // Advances the predicted parser by one accepted word and returns the result
  // word that it must produce.
  function automatic aifp_pkg::aifp_result_t parse_step(aifp_pkg::act_e act, logic [7:0] c);
    aifp_pkg::aifp_result_t r;
    field_phase_e p;
    field_phase_e after_sign;
    logic         took;
    logic [7:0]   d;
    r    = '0;
    took = 1'b0;
    if (act == aifp_pkg::ACT_START) begin
      fld_phase     = FP_SPACE;
      fld_count     = '0;
      fld_value     = '0;
      fld_negative  = 1'b0;
      fld_has_digit = 1'b0;
      case (mode_reg)
        aifp_pkg::RADIX_AUTO: fld_base = 5'd0;
        aifp_pkg::RADIX_OCT:  fld_base = 5'd8;
        aifp_pkg::RADIX_DEC:  fld_base = 5'd10;
        default:              fld_base = 5'd16;
      endcase
      return r;
    end
    if (act == aifp_pkg::ACT_NONE || fld_phase == FP_IDLE) return r;
    if (act == aifp_pkg::ACT_END) return close_field(1'b0);

    p = fld_phase;
    if (p == FP_SPACE) begin
      // Leading whitespace is taken but does not count toward the width.
      if (is_space(c)) begin
        r.consumed = 1'b1;
        return r;
      end
      p = FP_SIGN;
    end
    if (width_used_up()) return close_field(1'b0);

    after_sign = (fld_base == 5'd0 || fld_base == 5'd16) ? FP_LEAD_ZERO : FP_DIGITS;
    if (p == FP_SIGN) begin
      if (c == aifp_pkg::CH_MINUS || c == aifp_pkg::CH_PLUS) begin
        fld_negative = (c == aifp_pkg::CH_MINUS);
        took         = 1'b1;
        fld_phase    = after_sign;
      end else begin
        p = after_sign;
      end
    end
    if (!took && p == FP_LEAD_ZERO) begin
      if (c == aifp_pkg::CH_ZERO) begin
        fld_has_digit = 1'b1;
        took          = 1'b1;
        fld_phase     = FP_PREFIX_X;
      end else begin
        if (fld_base == 5'd0) fld_base = 5'd10;
        p = FP_DIGITS;
      end
    end
    if (!took && p == FP_PREFIX_X) begin
      if (c == aifp_pkg::CH_LOW_X || c == aifp_pkg::CH_UP_X) begin
        fld_base  = 5'd16;
        took      = 1'b1;
        fld_phase = FP_DIGITS;
      end else begin
        // A lone zero in automatic mode selects octal.
        if (fld_base == 5'd0) fld_base = 5'd8;
        p = FP_DIGITS;
      end
    end
    if (!took && p == FP_DIGITS) begin
      d = digit_weight(c);
      if (d < fld_base) begin
        fld_value     = fld_value * 64'(fld_base);
        fld_value     = fld_negative ? fld_value - 64'(d) : fld_value + 64'(d);
        fld_has_digit = 1'b1;
        fld_phase     = FP_DIGITS;
      end else begin
        return close_field(1'b0);
      end
    end

    if (fld_count != '1) fld_count++;
    if (width_used_up()) return close_field(1'b1);
    r.consumed = 1'b1;
    return r;
  endfunction

  function automatic step_t word_row(aifp_pkg::act_e a, logic [7:0] c);
    step_t s;
    s     = '0;
    s.act = a;
    s.arg = 16'(c);
    return s;
  endfunction

  function automatic step_t typed_row(aifp_pkg::act_e a, logic [7:0] c, logic took,
                                      logic done, logic good, logic [63:0] v);
    step_t s;
    s       = word_row(a, c);
    s.typed = 1'b1;
    s.want  = '{consumed: took, done_res: done, ok: good, value: v};
    return s;
  endfunction

  function automatic step_t reg_row(aifp_pkg::cfg_reg_e idx,
                                    logic [aifp_pkg::WIDTH_BITS-1:0] d);
    step_t s;
    s         = '0;
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.arg     = d;
    return s;
  endfunction

  // Character for a digit weight from 0 to 35, letters in random case.
  function automatic logic [7:0] digit_char(int unsigned v);
    logic [7:0] c;
    if (v < 10) begin
      c = aifp_pkg::CH_ZERO + 8'(v);
    end else begin
      c = ($urandom_range(0, 1) ? aifp_pkg::CH_LOW_A : aifp_pkg::CH_UP_A) + 8'(v - 10);
    end
    return c;
  endfunction

  function automatic logic [7:0] space_char();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? aifp_pkg::CH_SPACE : aifp_pkg::CH_TAB + 8'(r);
  endfunction

  // Sends one word, called and returning at a falling edge. The valid stays
  // high on return so that back-to-back words need no gap. The expectation is
  // queued at the accepting edge, before its result can show up.
  task automatic send_word(aifp_pkg::act_e act, logic [7:0] c, logic typed = 1'b0,
                           aifp_pkg::aifp_result_t want = '0);
    int unsigned            gap;
    aifp_pkg::aifp_result_t predicted;
    gap = idling ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid  = 1'b1;
    in_if.action = act;
    in_if.ch     = c;
    do @(posedge clk_i); while (!in_if.ready);
    sent_words++;
    predicted = parse_step(act, c);
    awaited_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Registers may only change with no word in flight, so the input side is
  // parked until every awaited result has come back.
  task automatic write_reg(aifp_pkg::cfg_reg_e idx, logic [aifp_pkg::WIDTH_BITS-1:0] d);
    in_if.valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = d;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == aifp_pkg::REG_RADIX_MODE) begin
      mode_reg = aifp_pkg::radix_e'(d[1:0]);
    end else begin
      width_reg = d;
    end
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // One number in text form: mostly a start, optional whitespace, sign and prefix,
  // digits valid for the latched radix, and mostly some way of ending the field.
  task automatic send_number();
    int unsigned sel;
    int unsigned n;
    int unsigned base;
    if ($urandom_range(0, 7) != 0) send_word(aifp_pkg::ACT_START, 8'($urandom_range(0, 255)));
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) send_word(aifp_pkg::ACT_CHAR, space_char());
    sel = $urandom_range(0, 2);
    if (sel == 0) send_word(aifp_pkg::ACT_CHAR, aifp_pkg::CH_MINUS);
    else if (sel == 1) send_word(aifp_pkg::ACT_CHAR, aifp_pkg::CH_PLUS);
    sel = $urandom_range(0, 5);
    if (sel < 2) send_word(aifp_pkg::ACT_CHAR, aifp_pkg::CH_ZERO);
    if (sel == 0) begin
      send_word(aifp_pkg::ACT_CHAR,
                $urandom_range(0, 1) ? aifp_pkg::CH_LOW_X : aifp_pkg::CH_UP_X);
    end
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 8);
    base = 10;
    for (int i = 0; i < n; i++) begin
      if (fld_phase == FP_IDLE) break;
      base = (fld_base != 0) ? fld_base : 10;
      send_word(aifp_pkg::ACT_CHAR, digit_char($urandom_range(0, base - 1)));
    end
    case ($urandom_range(0, 4))
      0: send_word(aifp_pkg::ACT_END, 8'($urandom_range(0, 255)));
      1: send_word(aifp_pkg::ACT_CHAR, 8'($urandom_range(0, 255)));
      2: send_word(aifp_pkg::ACT_CHAR, space_char());
      3: send_word(aifp_pkg::ACT_CHAR, digit_char($urandom_range(base, 35)));
      default: ;
    endcase
  endtask

  // Result side: a random stall before each word, then compare it with the
  // oldest expectation.
  initial begin : result_sink
    int unsigned            stall;
    aifp_pkg::aifp_result_t want;
    aifp_pkg::aifp_result_t got;
    string                  bad;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = idling ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got.consumed = out_if.consumed;
      got.done_res = out_if.done_res;
      got.ok       = out_if.ok;
      got.value    = out_if.value;
      if (awaited_results.size() == 0) begin
        report_mismatch("result word arrived with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        bad  = "";
        if (got.consumed !== want.consumed) bad = {bad, " consumed"};
        if (got.done_res !== want.done_res) bad = {bad, " done_res"};
        if (got.ok !== want.ok) bad = {bad, " ok"};
        if (got.value !== want.value) bad = {bad, " value"};
        if (bad != "") begin
          report_mismatch($sformatf("wrong%s: got %b/%b/%b/%0d, want %b/%b/%b/%0d", bad,
                                    got.consumed, got.done_res, got.ok, $signed(got.value),
                                    want.consumed, want.done_res, want.ok,
                                    $signed(want.value)));
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[%0t] timeout after %0d cycles", $time, cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    step_t                           directed [$];
    logic [aifp_pkg::WIDTH_BITS-1:0] width_pick;
    int unsigned                     phase_no;
    int unsigned                     phase_end;
    int unsigned                     guard;
    in_if.valid   = 1'b0;
    in_if.action  = aifp_pkg::ACT_NONE;
    in_if.ch      = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = aifp_pkg::REG_RADIX_MODE;
    cfg_if.data   = '0;
    idling        = 1'b1;
    fail_count    = 0;
    sent_words    = 0;
    mode_reg      = aifp_pkg::RADIX_DEC;
    width_reg     = '0;
    fld_phase     = FP_IDLE;
    fld_count     = '0;
    fld_value     = '0;
    fld_negative  = 1'b0;
    fld_has_digit = 1'b0;
    fld_base      = 5'd10;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed words, decimal mode and no width limit out of reset.
    directed = '{
      // Nothing is open yet, so a character does nothing at all.
      typed_row(aifp_pkg::ACT_CHAR, 8'hFF, 1'b0, 1'b0, 1'b0, '0),
      typed_row(aifp_pkg::ACT_START, 8'h00, 1'b0, 1'b0, 1'b0, '0),
      typed_row(aifp_pkg::ACT_CHAR, aifp_pkg::CH_SPACE, 1'b1, 1'b0, 1'b0, '0),
      word_row(aifp_pkg::ACT_CHAR, aifp_pkg::CH_MINUS),
      word_row(aifp_pkg::ACT_CHAR, aifp_pkg::CH_NINE),
      // Action three is ignored even in the middle of a field.
      typed_row(aifp_pkg::ACT_NONE, aifp_pkg::CH_ZERO, 1'b0, 1'b0, 1'b0, '0),
      typed_row(aifp_pkg::ACT_END, 8'h00, 1'b0, 1'b1, 1'b1, -64'sd9),
      // No digit at all is a failure.
      word_row(aifp_pkg::ACT_START, 8'h00),
      typed_row(aifp_pkg::ACT_CHAR, aifp_pkg::CH_LOW_X, 1'b0, 1'b1, 1'b0, '0),
      // Automatic mode: a prefix with no digits after it still counts as 0,
      // and a lone zero switches to octal.
      reg_row(aifp_pkg::REG_RADIX_MODE, 16'(aifp_pkg::RADIX_AUTO)),
      word_row(aifp_pkg::ACT_START, 8'h00),
      word_row(aifp_pkg::ACT_CHAR, aifp_pkg::CH_ZERO),
      word_row(aifp_pkg::ACT_CHAR, aifp_pkg::CH_UP_X),
      typed_row(aifp_pkg::ACT_CHAR, "g", 1'b0, 1'b1, 1'b1, '0),
      word_row(aifp_pkg::ACT_START, 8'h00),
      word_row(aifp_pkg::ACT_CHAR, aifp_pkg::CH_ZERO),
      typed_row(aifp_pkg::ACT_CHAR, "8", 1'b0, 1'b1, 1'b1, '0),
      // A start in the middle of a field drops it without a word of notice.
      word_row(aifp_pkg::ACT_START, 8'h00),
      word_row(aifp_pkg::ACT_CHAR, "7"),
      typed_row(aifp_pkg::ACT_START, 8'h00, 1'b0, 1'b0, 1'b0, '0),
      word_row(aifp_pkg::ACT_CHAR, "1"),
      typed_row(aifp_pkg::ACT_END, 8'h00, 1'b0, 1'b1, 1'b1, 64'd1),
      // The character that uses up the width closes the field and is taken.
      reg_row(aifp_pkg::REG_RADIX_MODE, 16'(aifp_pkg::RADIX_HEX)),
      reg_row(aifp_pkg::REG_FIELD_WIDTH, 16'd2),
      word_row(aifp_pkg::ACT_START, 8'h00),
      word_row(aifp_pkg::ACT_CHAR, aifp_pkg::CH_MINUS),
      typed_row(aifp_pkg::ACT_CHAR, aifp_pkg::CH_UP_F, 1'b1, 1'b1, 1'b1, -64'sd15),
      // The radix stays latched when the mode changes under an open field.
      reg_row(aifp_pkg::REG_FIELD_WIDTH, 16'd0),
      reg_row(aifp_pkg::REG_RADIX_MODE, 16'(aifp_pkg::RADIX_OCT)),
      word_row(aifp_pkg::ACT_START, 8'h00),
      word_row(aifp_pkg::ACT_CHAR, "1"),
      reg_row(aifp_pkg::REG_RADIX_MODE, 16'(aifp_pkg::RADIX_HEX)),
      typed_row(aifp_pkg::ACT_CHAR, "a", 1'b0, 1'b1, 1'b1, 64'd1),
      // A width lowered below the count ends the field at the next character.
      word_row(aifp_pkg::ACT_START, 8'h00),
      word_row(aifp_pkg::ACT_CHAR, "1"),
      word_row(aifp_pkg::ACT_CHAR, "2"),
      reg_row(aifp_pkg::REG_FIELD_WIDTH, 16'd1),
      typed_row(aifp_pkg::ACT_CHAR, "3", 1'b0, 1'b1, 1'b1, 64'd18)
    };
    foreach (directed[i]) begin
      if (directed[i].is_reg) begin
        write_reg(directed[i].reg_idx, directed[i].arg);
      end else begin
        send_word(directed[i].act, directed[i].arg[7:0], directed[i].typed,
                  directed[i].want);
      end
    end

    // Random part: mostly well-formed numbers, some noise, and a new setting
    // every phase. A field may stay open across a phase change.
    phase_no = 0;
    while (sent_words < ITEM_COUNT) begin
      write_reg(aifp_pkg::REG_RADIX_MODE,
                16'((phase_no < 4) ? phase_no : $urandom_range(0, 3)));
      case (phase_no)
        0: width_pick = 16'd0;
        1: width_pick = 16'hFFFF;
        2: width_pick = 16'd1;
        default: begin
          case ($urandom_range(0, 5))
            0, 1:    width_pick = 16'd0;
            2:       width_pick = 16'($urandom_range(1, 3));
            3:       width_pick = 16'($urandom_range(4, 24));
            4:       width_pick = 16'hFFFF;
            default: width_pick = 16'($urandom_range(0, 65535));
          endcase
        end
      endcase
      write_reg(aifp_pkg::REG_FIELD_WIDTH, width_pick);
      idling    = ($urandom_range(0, 4) != 0);
      phase_end = sent_words + PHASE_WORDS;
      while (sent_words < phase_end && sent_words < ITEM_COUNT) begin
        if ($urandom_range(0, 4) != 0) begin
          send_number();
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_word(aifp_pkg::act_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          end
        end
      end
      phase_no++;
    end

    in_if.valid = 1'b0;
    guard       = 0;
    while (awaited_results.size() != 0 && guard < 2000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (awaited_results.size() != 0) begin
      report_mismatch($sformatf("%0d result words never arrived", awaited_results.size()));
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
sv/aifp_pkg.sv
sv/aifp_intf.sv
sv/aifp_front.sv
sv/aifp_fifo.sv
sv/aifp_back.sv
sv/ascii_integer_field_parser.sv
tb/tb_ascii_integer_field_parser.sv
